// ===== src/rgb565_hsl_color_classifier_top_defines.svh =====
// assertion helpers used by the classifier top
`ifndef RGB565_HSL_COLOR_CLASSIFIER_TOP_DEFINES_SVH
`define RGB565_HSL_COLOR_CLASSIFIER_TOP_DEFINES_SVH

// checked while out of reset
`define RGBHSL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rgbhsl assertion failed");

// checked on every rising clock edge, reset included
`define RGBHSL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("rgbhsl assertion failed");

`endif

// ===== src/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

   localparam int QBITS = 8;

   localparam logic [5:0]  HUE_SPAN     = 6'd40;
   localparam logic [7:0]  HUE_GREEN    = 8'd80;
   localparam logic [7:0]  HUE_BLUE     = 8'd160;
   localparam logic [7:0]  HUE_WRAP     = 8'd240;
   localparam logic [7:0]  SCALE_MAX    = 8'd240;
   localparam logic [7:0]  SAT_SCALE    = 8'd240;
   localparam logic [8:0]  SAT_REFLECT  = 9'd511;
   localparam logic [8:0]  LUM_ZERO_SUM = 9'd2;
   localparam logic [8:0]  LUM_HIGH_SUM = 9'd258;
   localparam logic [11:0] LUM_RECIP    = 12'd3856;

   typedef enum logic [2:0] {
      REG_HUE_MIN        = 3'd0,
      REG_HUE_MAX        = 3'd1,
      REG_SAT_MIN        = 3'd2,
      REG_SAT_MAX        = 3'd3,
      REG_LUM_MIN        = 3'd4,
      REG_LUM_MAX        = 3'd5,
      REG_GRAY_THRESHOLD = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [13:0] hue_rem;
      logic [7:0]  hue_div;
      logic [7:0]  hue_q;
      logic [15:0] sat_rem;
      logic [8:0]  sat_div;
      logic [7:0]  sat_q;
      logic [7:0]  lum;
      logic        hue_neg;
      logic [7:0]  hue_base;
      logic        gray;
   } work_type;

   typedef struct packed {
      logic [7:0] hue_min;
      logic [7:0] hue_max;
      logic [7:0] sat_min;
      logic [7:0] sat_max;
      logic [7:0] lum_min;
      logic [7:0] lum_max;
      logic [7:0] gray_threshold;
   } cfg_type;

endpackage

// ===== src/rgb565_hsl_color_classifier_top.sv =====
// RGB565 to HSL (0..240 scale) pixel classifier. Each req_ transaction carries one pixel;
// each rsp_ transaction returns hue, saturation, luminance, an in-bounds match flag and a
// brightness flag, in order. A new pixel can be taken every cycle unless a stall on rsp_ready
// holds the cells. Each pixel is registered in turn by the cells of the pipe, in this order:
// one front cell (channel expand, max/min, luminance, divider setup), a row of 8 divider
// cells that each settle one quotient bit of the hue and the saturation division, and one
// output cell (offset, clamp, bound compares). Every cell
// holds its transaction until the next cell can take it, so stalls on rsp_ready back up
// cell by cell. Bound registers are written through the csr_ port and should only be
// changed while no pixel is in flight; index 7 is ignored.
module rgb565_hsl_color_classifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_hue,
   output logic [7:0]  rsp_saturation,
   output logic [7:0]  rsp_luminance,
   output logic        rsp_is_match,
   output logic        rsp_is_bright,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

`include "rgb565_hsl_color_classifier_top_defines.svh"

   localparam int NCELL = rgbhsl_pkg::QBITS;

   rgbhsl_pkg::cfg_type  cfg_ff, cfg_in;
   rgbhsl_pkg::work_type chain_data [NCELL+1];
   logic                 chain_valid [NCELL+1];
   logic                 chain_ready [NCELL+1];

   // config writes always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (rgbhsl_pkg::reg_index_type'(csr_index))
            rgbhsl_pkg::REG_HUE_MIN:        cfg_in.hue_min        = csr_wdata;
            rgbhsl_pkg::REG_HUE_MAX:        cfg_in.hue_max        = csr_wdata;
            rgbhsl_pkg::REG_SAT_MIN:        cfg_in.sat_min        = csr_wdata;
            rgbhsl_pkg::REG_SAT_MAX:        cfg_in.sat_max        = csr_wdata;
            rgbhsl_pkg::REG_LUM_MIN:        cfg_in.lum_min        = csr_wdata;
            rgbhsl_pkg::REG_LUM_MAX:        cfg_in.lum_max        = csr_wdata;
            rgbhsl_pkg::REG_GRAY_THRESHOLD: cfg_in.gray_threshold = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_min        <= 8'd0;
         cfg_ff.hue_max        <= 8'd255;
         cfg_ff.sat_min        <= 8'd0;
         cfg_ff.sat_max        <= 8'd255;
         cfg_ff.lum_min        <= 8'd0;
         cfg_ff.lum_max        <= 8'd255;
         cfg_ff.gray_threshold <= 8'd120;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front cell
   rgbhsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pixel     (req_pixel),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // divider row, msb quotient bit first
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      rgbhsl_div_cell #(
         .SHIFT (NCELL - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // output cell doubles as the result register
   rgbhsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[NCELL]),
      .in_ready   (chain_ready[NCELL]),
      .in_data    (chain_data[NCELL]),
      .cfg        (cfg_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .luminance  (rsp_luminance),
      .is_match   (rsp_is_match),
      .is_bright  (rsp_is_bright)
   );

   `RGBHSL_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> (rsp_hue <= 8'd240 && rsp_saturation <= 8'd240 && rsp_luminance <= 8'd240))
   `RGBHSL_ASSERT(a_bright_flag, clock, reset, rsp_valid |-> (rsp_is_bright == (rsp_luminance > cfg_ff.gray_threshold)))
   `RGBHSL_ASSERT(a_reset_empty, clock, reset, $past(reset) |-> !rsp_valid)

endmodule

// ===== src/rgbhsl_front.sv =====
module rgbhsl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [15:0]         pixel,
   output logic                out_valid,
   input  logic                out_ready,
   output rgbhsl_pkg::work_type out_data
);

   logic                 valid_ff, valid_in;
   rgbhsl_pkg::work_type data_ff, data_in;
   logic [7:0]  r, g, b, mx, mn, d, mag;
   logic [8:0]  sum;
   logic [23:0] lum_prod;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_comb begin
      r = {pixel[15:11], 3'b000};
      g = {pixel[10:5], 2'b00};
      b = {pixel[4:0], 3'b000};
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sum = 9'(mx) + 9'(mn);
      // sum*240/255/2 == sum*8/17, done with a reciprocal
      lum_prod = 24'({sum, 3'b000}) * 24'(rgbhsl_pkg::LUM_RECIP);

      data_in = data_ff;
      priority if (mx == r) begin
         data_in.hue_neg  = g < b;
         mag              = (g < b) ? b - g : g - b;
         data_in.hue_base = (g < b) ? rgbhsl_pkg::HUE_WRAP : 8'd0;
      end else if (mx == g) begin
         data_in.hue_neg  = b < r;
         mag              = (b < r) ? r - b : b - r;
         data_in.hue_base = rgbhsl_pkg::HUE_GREEN;
      end else begin
         data_in.hue_neg  = r < g;
         mag              = (r < g) ? g - r : r - g;
         data_in.hue_base = rgbhsl_pkg::HUE_BLUE;
      end
      data_in.hue_rem = 14'(mag) * 14'(rgbhsl_pkg::HUE_SPAN);
      data_in.hue_div = d;
      data_in.hue_q   = '0;
      data_in.sat_rem = 16'(d) * 16'(rgbhsl_pkg::SAT_SCALE);
      // zero luminance or the bright half divides by the reflected sum
      data_in.sat_div = (sum <= rgbhsl_pkg::LUM_ZERO_SUM || sum >= rgbhsl_pkg::LUM_HIGH_SUM)
                        ? rgbhsl_pkg::SAT_REFLECT - sum : sum;
      data_in.sat_q   = '0;
      data_in.lum     = lum_prod[23:16];
      data_in.gray    = (d == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/rgbhsl_div_cell.sv =====
module rgbhsl_div_cell #(
   parameter int SHIFT = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rgbhsl_pkg::work_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rgbhsl_pkg::work_type out_data
);

   logic                 valid_ff, valid_in;
   rgbhsl_pkg::work_type data_ff, data_in;
   logic [23:0] hue_shift, sat_shift;
   logic        hue_ge, sat_ge;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   // one restoring quotient bit for each divider
   always_comb begin
      hue_shift = 24'(in_data.hue_div) << SHIFT;
      sat_shift = 24'(in_data.sat_div) << SHIFT;
      hue_ge    = 24'(in_data.hue_rem) >= hue_shift;
      sat_ge    = 24'(in_data.sat_rem) >= sat_shift;
      data_in   = in_data;
      data_in.hue_rem = hue_ge ? 14'(24'(in_data.hue_rem) - hue_shift) : in_data.hue_rem;
      data_in.sat_rem = sat_ge ? 16'(24'(in_data.sat_rem) - sat_shift) : in_data.sat_rem;
      data_in.hue_q   = {in_data.hue_q[6:0], hue_ge};
      data_in.sat_q   = {in_data.sat_q[6:0], sat_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/rgbhsl_back.sv =====
module rgbhsl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rgbhsl_pkg::work_type in_data,
   input  rgbhsl_pkg::cfg_type  cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          hue,
   output logic [7:0]          saturation,
   output logic [7:0]          luminance,
   output logic                is_match,
   output logic                is_bright
);

   logic       valid_ff, valid_in;
   logic [7:0] hue_ff, hue_in, sat_ff, sat_in, lum_ff, lum_in;
   logic       match_ff, match_in, bright_ff, bright_in;
   logic [8:0] hue_raw;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign luminance  = lum_ff;
   assign is_match   = match_ff;
   assign is_bright  = bright_ff;
   assign valid_in   = in_ready ? in_valid : valid_ff;

   always_comb begin
      hue_raw = in_data.hue_neg ? 9'(in_data.hue_base) - 9'(in_data.hue_q)
                                : 9'(in_data.hue_base) + 9'(in_data.hue_q);
      if (in_data.gray) begin
         hue_in = 8'd0;
         sat_in = 8'd0;
      end else begin
         hue_in = (hue_raw > 9'(rgbhsl_pkg::SCALE_MAX)) ? rgbhsl_pkg::SCALE_MAX : hue_raw[7:0];
         sat_in = (in_data.sat_q > rgbhsl_pkg::SCALE_MAX) ? rgbhsl_pkg::SCALE_MAX
                                                           : in_data.sat_q;
      end
      lum_in = (in_data.lum > rgbhsl_pkg::SCALE_MAX) ? rgbhsl_pkg::SCALE_MAX : in_data.lum;
      match_in = (hue_in > cfg.hue_min) && (hue_in < cfg.hue_max) &&
                 (sat_in > cfg.sat_min) && (sat_in < cfg.sat_max) &&
                 (lum_in > cfg.lum_min) && (lum_in < cfg.lum_max);
      bright_in = lum_in > cfg.gray_threshold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         lum_ff    <= lum_in;
         match_ff  <= match_in;
         bright_ff <= bright_in;
      end
   end

endmodule

// ===== verif/tb_rgb565_hsl_color_classifier_top.sv =====
module tb_rgb565_hsl_color_classifier_top;

   // one expected classification per accepted pixel
   typedef struct {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] lum;
      logic       is_match;
      logic       is_bright;
   } hsl_result_type;

   // in-order store of expected classifications plus the predictor
   class hsl_scoreboard;
      logic [7:0]     bounds [7];
      hsl_result_type pending [$];
      int             errors;
      int             checked;
      int             match_count;
      int             brights;

      function void set_defaults();
         bounds[rgbhsl_pkg::REG_HUE_MIN] = 8'd0;
         bounds[rgbhsl_pkg::REG_HUE_MAX] = 8'd255;
         bounds[rgbhsl_pkg::REG_SAT_MIN] = 8'd0;
         bounds[rgbhsl_pkg::REG_SAT_MAX] = 8'd255;
         bounds[rgbhsl_pkg::REG_LUM_MIN] = 8'd0;
         bounds[rgbhsl_pkg::REG_LUM_MAX] = 8'd255;
         bounds[rgbhsl_pkg::REG_GRAY_THRESHOLD] = 8'd120;
      endfunction

      function int clamp_scale(int v);
         if (v > 240) return 240;
         if (v < 0) return 0;
         return v;
      endfunction

      // note one accepted pixel and queue its classification
      function void note_pixel(logic [15:0] px);
         int r, g, b, mx, mn, d, sum, h, s, l;
         hsl_result_type e;
         r = int'(px[15:11]) << 3;
         g = int'(px[10:5]) << 2;
         b = int'(px[4:0]) << 3;
         mx = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         mn = r;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = mx - mn;
         sum = mx + mn;
         l = (sum * 240 / 255) / 2;
         if (d == 0) begin
            h = 0;
            s = 0;
         end else begin
            // sv int division truncates toward zero like c
            if (mx == r) begin
               h = 40 * (g - b) / d;
               if (g < b) h += 240;
            end else if (mx == g) begin
               h = 40 * (b - r) / d + 80;
            end else begin
               h = 40 * (r - g) / d + 160;
            end
            if (l == 0 || l > 120) s = d * 240 / (511 - sum);
            else s = d * 240 / sum;
         end
         e.hue = 8'(clamp_scale(h));
         e.sat = 8'(clamp_scale(s));
         e.lum = 8'(clamp_scale(l));
         e.is_match = e.hue > bounds[rgbhsl_pkg::REG_HUE_MIN] &&
                      e.hue < bounds[rgbhsl_pkg::REG_HUE_MAX] &&
                      e.sat > bounds[rgbhsl_pkg::REG_SAT_MIN] &&
                      e.sat < bounds[rgbhsl_pkg::REG_SAT_MAX] &&
                      e.lum > bounds[rgbhsl_pkg::REG_LUM_MIN] &&
                      e.lum < bounds[rgbhsl_pkg::REG_LUM_MAX];
         e.is_bright = e.lum > bounds[rgbhsl_pkg::REG_GRAY_THRESHOLD];
         pending.push_back(e);
      endfunction

      function void compare(string field, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(hsl_result_type act);
         hsl_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none actual hue %0d", $time, act.hue);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         match_count += act.is_match;
         brights += act.is_bright;
         compare("hue", e.hue, act.hue);
         compare("saturation", e.sat, act.sat);
         compare("luminance", e.lum, act.lum);
         compare("is_match", e.is_match, act.is_match);
         compare("is_bright", e.is_bright, act.is_bright);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_hue;
   logic [7:0]  rsp_saturation;
   logic [7:0]  rsp_luminance;
   logic        rsp_is_match;
   logic        rsp_is_bright;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   hsl_scoreboard sb = new();
   int  idle_pct = 31;      // shared idle rate for both sides
   bit  hold_off = 1'b0;    // asks the receiver for a long stall
   int  pixels_sent = 0;

   rgb565_hsl_color_classifier_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // send one pixel, holding it until accepted; random gaps before
   task automatic send_pixel(logic [15:0] px);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px);
      pixels_sent++;
      @(negedge clock);
   endtask

   // write one bound register while nothing is in flight
   task automatic write_bound(rgbhsl_pkg::reg_index_type idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx <= rgbhsl_pkg::REG_GRAY_THRESHOLD) sb.bounds[idx] = val;
      @(negedge clock);
   endtask

   // an out-of-range index must be ignored
   task automatic write_bad_index(logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= 3'd7;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_bounds(logic [7:0] hmin, logic [7:0] hmax, logic [7:0] smin,
                             logic [7:0] smax, logic [7:0] lmin, logic [7:0] lmax,
                             logic [7:0] thr);
      drain();
      write_bound(rgbhsl_pkg::REG_HUE_MIN, hmin);
      write_bound(rgbhsl_pkg::REG_HUE_MAX, hmax);
      write_bound(rgbhsl_pkg::REG_SAT_MIN, smin);
      write_bound(rgbhsl_pkg::REG_SAT_MAX, smax);
      write_bound(rgbhsl_pkg::REG_LUM_MIN, lmin);
      write_bound(rgbhsl_pkg::REG_LUM_MAX, lmax);
      write_bound(rgbhsl_pkg::REG_GRAY_THRESHOLD, thr);
      csr_valid <= 1'b0;
   endtask

   // pixels biased toward chroma-heavy and near-gray colors
   function automatic logic [15:0] random_pixel();
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] b5;
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: begin
            // near gray: channels close to one another
            r5 = 5'($urandom);
            g6 = {r5, 1'($urandom)};
            b5 = r5 ^ 5'($urandom_range(1));
            return {r5, g6, b5};
         end
         2: begin
            // red and green each saturated or near zero, blue random
            r5 = $urandom_range(1) ? 5'h1f : 5'($urandom_range(3));
            g6 = $urandom_range(1) ? 6'h3f : 6'($urandom_range(7));
            b5 = 5'($urandom);
            return {r5, g6, b5};
         end
         default: return {5'($urandom), 6'($urandom), 5'($urandom)};
      endcase
   endfunction

   // result side: random back-pressure, plus a long stall on request
   initial begin
      hsl_result_type act;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            act.hue = rsp_hue;
            act.sat = rsp_saturation;
            act.lum = rsp_luminance;
            act.is_match = rsp_is_match;
            act.is_bright = rsp_is_bright;
            sb.check_result(act);
         end
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      logic [15:0] directed [] = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f,
                                  16'hffe0, 16'h07ff, 16'hf81f, 16'h8410, 16'h0841,
                                  16'hf810, 16'h801f, 16'h07f0, 16'h0020, 16'h0001,
                                  16'h0800, 16'h7bef, 16'h8000, 16'h0400, 16'h0010,
                                  16'haaaa, 16'h5555};
      sb.set_defaults();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, primaries, grays and hue wrap cases at reset bounds
      foreach (directed[i]) send_pixel(directed[i]);

      // mid-range window, then a bogus index write that must not stick
      set_bounds(8'd20, 8'd200, 8'd10, 8'd230, 8'd30, 8'd210, 8'd60);
      write_bad_index(8'd0);
      for (int i = 0; i < 200; i++) send_pixel(random_pixel());

      // long receiver stall while pixels keep coming, so the pipe fills
      hold_off = 1'b1;
      for (int i = 0; i < 40; i++) send_pixel(random_pixel());

      // sender pause until every classification is back
      drain();

      // no idling at all for a stretch
      idle_pct = 0;
      for (int i = 0; i < 150; i++) send_pixel(random_pixel());
      idle_pct = 31;

      // extremes: empty windows, widest windows and a narrow edge window
      set_bounds(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
      for (int i = 0; i < 100; i++) send_pixel(random_pixel());
      set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
      for (int i = 0; i < 100; i++) send_pixel(random_pixel());
      set_bounds(8'd239, 8'd241, 8'd0, 8'd241, 8'd119, 8'd240, 8'd240);
      for (int i = 0; i < 80; i++) send_pixel(random_pixel());

      // random windows
      for (int k = 0; k < 5; k++) begin
         set_bounds(8'($urandom_range(120)), 8'($urandom_range(120, 255)),
                    8'($urandom_range(120)), 8'($urandom_range(120, 255)),
                    8'($urandom_range(120)), 8'($urandom_range(120, 255)),
                    8'($urandom));
         for (int i = 0; i < 52; i++) send_pixel(random_pixel());
      end

      drain();
      $display("covered %0d pixels, %0d results checked, %0d matched, %0d bright",
               pixels_sent, sb.checked, sb.match_count, sb.brights);
      $display("bound windows from empty to full plus stall and burst phases");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/rgbhsl_pkg.sv
src/rgbhsl_front.sv
src/rgbhsl_div_cell.sv
src/rgbhsl_back.sv
src/rgb565_hsl_color_classifier_top.sv
verif/tb_rgb565_hsl_color_classifier_top.sv
